FILE: rtl/lrc_pkg.sv
// Package for the line reversing Caesar cipher.
// Holds widths, character constants, register indexes and the substitution function.
// No dependencies.
`default_nettype none
package lrc_pkg;

    localparam int LRC_LINE_CAPACITY = 63;
    localparam int CHAR_W = 8;
    localparam int KEY_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 1'b1;

    localparam logic [KEY_W-1:0] KEY_RESET = 5'd3;

    localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_DOT = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_STAR = 8'd42;
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'd95;
    localparam logic [CHAR_W-1:0] CHAR_A = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_Z = 8'd122;
    localparam logic [CHAR_W-1:0] ALPHA_LEN = 8'd26;

    function automatic logic [CHAR_W-1:0] subst(input logic [CHAR_W-1:0] c,
                                                input logic [KEY_W-1:0] k,
                                                input logic decrypt);
        logic [CHAR_W:0] c_wide;
        logic [CHAR_W:0] k_wide;
        logic [CHAR_W-1:0] result;
        c_wide = {1'b0, c};
        k_wide = (CHAR_W + 1)'(k);
        if (!decrypt) begin
            if (c == CHAR_SPACE) begin
                result = CHAR_UNDER;
            end else if (c == CHAR_DOT) begin
                result = CHAR_STAR;
            end else if (c_wide < k_wide + {1'b0, CHAR_A}) begin
                result = c - CHAR_W'(k) + ALPHA_LEN;
            end else begin
                result = c - CHAR_W'(k);
            end
        end else begin
            if (c == CHAR_UNDER) begin
                result = CHAR_SPACE;
            end else if (c == CHAR_STAR) begin
                result = CHAR_DOT;
            end else if (c_wide + k_wide > {1'b0, CHAR_Z}) begin
                result = c + CHAR_W'(k) - ALPHA_LEN;
            end else begin
                result = c + CHAR_W'(k);
            end
        end
        return result;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lrc_in_if.sv
// Input channel interface: one message byte and its end of message mark.
// Depends on lrc_pkg.
`default_nettype none
interface lrc_in_if;
    logic valid;
    logic ready;
    logic [lrc_pkg::CHAR_W-1:0] char_in;
    logic end_of_message;

    modport source (output valid, output char_in, output end_of_message, input ready);
    modport sink (input valid, input char_in, input end_of_message, output ready);
endinterface
`default_nettype wire

FILE: rtl/lrc_out_if.sv
// Output channel interface: one substituted byte with its last and truncated flags.
// Depends on lrc_pkg.
`default_nettype none
interface lrc_out_if;
    logic valid;
    logic ready;
    logic [lrc_pkg::CHAR_W-1:0] char_out;
    logic last;
    logic truncated;

    modport source (output valid, output char_out, output last, output truncated, input ready);
    modport sink (input valid, input char_out, input last, input truncated, output ready);
endinterface
`default_nettype wire

FILE: rtl/line_reverse_caesar_cipher.sv
// Top level of the line reversing Caesar cipher.
// Depends on lrc_pkg, lrc_in_if, lrc_out_if and lrc_ram.
//
// Usage: bytes arrive as transactions on in_ch and are written into the line RAM.
// A newline, or a byte marked end_of_message, flushes the line: its bytes come out
// on out_ch in reverse order, substituted with the current key and mode, followed
// by the newline when the flushing byte is one. The final transaction of a flush
// carries last, and every transaction of it carries truncated if the line lost
// bytes beyond the buffer capacity.
// A flush issues one RAM read at a time, only when none is pending and the output
// register is free or being taken. in_ch is ready again once the last read of a
// flush is issued, or once its newline enters the output register; receiver
// stalls delay this. The first result is read from the RAM and then loaded into
// the output register; an empty line loads its newline directly. On a receiver
// stall the output register holds its transaction and no further read is issued.
// Reset clears the line count, the overflow flag and the output register, and
// restores key 3 and encrypt mode; the RAM is not cleared. Configuration writes
// on cfg_we, cfg_index and cfg_data take effect at once; the user must make them
// only while no line is held or being flushed, as the block does not enforce it.
`default_nettype none
module line_reverse_caesar_cipher #(
    parameter int LINE_CAPACITY = lrc_pkg::LRC_LINE_CAPACITY
) (
    input wire logic clk,
    input wire logic rst_n,
    lrc_in_if.sink in_ch,
    lrc_out_if.source out_ch,
    input wire logic cfg_we,
    input wire logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [lrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lrc_pkg::*;

    localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    typedef enum logic [1:0] {S_IN, S_READ, S_NL} state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic nl_pend_reg, nl_pend_next;
    logic trunc_hold_reg, trunc_hold_next;
    logic rd_pend_reg, rd_pend_next;
    logic rd_last_reg, rd_last_next;
    logic out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic out_last_reg, out_last_next;
    logic out_trunc_reg, out_trunc_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic mode_reg, mode_next;

    logic in_acc;
    logic is_nl;
    logic room;
    logic store;
    logic flush;
    logic out_free;
    logic issue;
    logic nl_load;
    logic [CNT_W-1:0] new_cnt;
    logic [CHAR_W-1:0] rdata;

    assign in_ch.ready = (state_reg == S_IN);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign is_nl = (in_ch.char_in == CHAR_NL);
    assign room = (cnt_reg < CNT_W'(LINE_CAPACITY));
    assign store = in_acc && !is_nl && room;
    assign flush = is_nl || in_ch.end_of_message;
    assign new_cnt = cnt_reg + CNT_W'(store);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign issue = (state_reg == S_READ) && !rd_pend_reg && out_free;
    assign nl_load = (state_reg == S_NL) && !rd_pend_reg && out_free;

    lrc_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(LINE_CAPACITY)
    ) u_line_ram (
        .clk(clk),
        .we(store),
        .waddr(cnt_reg[ADDR_W-1:0]),
        .wdata(in_ch.char_in),
        .re(issue),
        .raddr(rd_idx_reg),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        rd_idx_next = rd_idx_reg;
        nl_pend_next = nl_pend_reg;
        trunc_hold_next = trunc_hold_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_trunc_next = out_trunc_reg;
        key_next = key_reg;
        mode_next = mode_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_KEY: key_next = cfg_data[KEY_W-1:0];
                CFG_IDX_MODE: mode_next = cfg_data[0];
                default: ;
            endcase
        end

        if (in_acc)
        begin
            if (!flush)
            begin
                cnt_next = new_cnt;
                ovf_next = ovf_reg || !room;
            end
            else
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
                trunc_hold_next = ovf_reg || (!is_nl && !room);
                nl_pend_next = is_nl;
                rd_idx_next = ADDR_W'(new_cnt - CNT_W'(1));
                if (new_cnt != '0)
                begin
                    state_next = S_READ;
                end
                else if (is_nl)
                begin
                    state_next = S_NL;
                end
            end
        end

        if (issue)
        begin
            rd_pend_next = 1'b1;
            rd_last_next = (rd_idx_reg == '0) && !nl_pend_reg;
            if (rd_idx_reg == '0)
            begin
                state_next = nl_pend_reg ? S_NL : S_IN;
            end
            else
            begin
                rd_idx_next = rd_idx_reg - ADDR_W'(1);
            end
        end

        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            out_char_next = subst(rdata, key_reg, mode_reg);
            out_last_next = rd_last_reg;
            out_trunc_next = trunc_hold_reg;
        end
        else if (nl_load)
        begin
            out_valid_next = 1'b1;
            out_char_next = CHAR_NL;
            out_last_next = 1'b1;
            out_trunc_next = trunc_hold_reg;
            state_next = S_IN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            rd_idx_reg <= '0;
            nl_pend_reg <= 1'b0;
            trunc_hold_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg <= '0;
            out_last_reg <= 1'b0;
            out_trunc_reg <= 1'b0;
            key_reg <= KEY_RESET;
            mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            rd_idx_reg <= rd_idx_next;
            nl_pend_reg <= nl_pend_next;
            trunc_hold_reg <= trunc_hold_next;
            rd_pend_reg <= rd_pend_next;
            rd_last_reg <= rd_last_next;
            out_valid_reg <= out_valid_next;
            out_char_reg <= out_char_next;
            out_last_reg <= out_last_next;
            out_trunc_reg <= out_trunc_next;
            key_reg <= key_next;
            mode_reg <= mode_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.char_out = out_char_reg;
    assign out_ch.last = out_last_reg;
    assign out_ch.truncated = out_trunc_reg;

`ifndef SYNTH
    a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("read data arrived while the output register was occupied");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LINE_CAPACITY))
        else $error("line count exceeds the buffer capacity");

    a_plain_byte_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !flush) |=> (state_reg == S_IN && rd_pend_reg == 1'b0))
        else $error("an ordinary byte started a flush");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && flush) |=> (cnt_reg == '0 && !ovf_reg))
        else $error("line state not cleared after a flush");
`endif

endmodule
`default_nettype wire

FILE: rtl/lrc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module lrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [ADDR_W-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic re,
    input wire logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
